FILE: rtl/crep_pkg.sv
// Shared types and codes for the credit ring endpoint.
package crep_pkg;

  // Command codes of an input item
  localparam logic CMD_SEND   = 1'b0;
  localparam logic CMD_ARRIVE = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_SENT      = 2'd0;
  localparam logic [1:0] ST_NO_CREDIT = 2'd1;
  localparam logic [1:0] ST_ARRIVED   = 2'd2;
  localparam logic [1:0] ST_IDLE      = 2'd3;

  // Configuration register indexes (byte address bit 2)
  localparam logic REG_OWED_LIMIT    = 1'b0;
  localparam logic REG_DRAIN_TARGET  = 1'b1;

  localparam int unsigned CNT_W = 32;

  typedef struct packed {
    logic        command;
    logic [7:0]  msg_type;
    logic [5:0]  peer_credit;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             out_valid;
    logic [7:0]       out_type;
    logic [5:0]       out_credit;
    logic [5:0]       out_slot;
    logic [63:0]      out_payload;
    logic [CNT_W-1:0] type_total;
    logic [5:0]       send_space;
    logic             drain_done;
  } rsp_t;

endpackage

FILE: rtl/credit_ring_endpoint.sv
// Credit ring endpoint: send/arrival processing with per-type counters in memory.
//
//  channel | signals                          | direction
//  --------+----------------------------------+----------
//  req     | req_valid, req_stall, req        | in
//  rsp     | rsp_valid, rsp_stall, rsp        | out
//  apb     | psel, penable, pwrite, paddr,    | in/out
//          | pwdata, prdata, pready           |
//
// One item is taken every cycle unless req_stall is high; a result passes from
// the compute stage into the output register and leaves when the output is not
// stalled. The counter memories are read at transfer and written back from the
// compute stage as the item leaves it, with the last write forwarded to the next
// item. Reset (rst, synchronous) clears the pointers, the counter valid bits and
// the output valid bit; no clearing pass is needed. A stalled output holds the
// item in the compute stage and stalls the input in the same cycle.
module credit_ring_endpoint
  import crep_pkg::*;
#(
  parameter int RING_SLOTS = 64,
  parameter int TYPE_COUNT = 8,
  parameter int IDLE_CODE  = 0,
  parameter int NOP_CODE   = 1,
  parameter int PUT_CODE   = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PTR_W = $clog2(RING_SLOTS);
  localparam int TW    = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;
  localparam logic [TW-1:0] NOP_IDX = (NOP_CODE < TYPE_COUNT) ? TW'(NOP_CODE) : '0;
  localparam logic [TW-1:0] PUT_IDX = (PUT_CODE < TYPE_COUNT) ? TW'(PUT_CODE) : '0;

  function automatic logic [TW-1:0] clamp_type(input logic [7:0] t);
    return (32'(t) < 32'(TYPE_COUNT)) ? TW'(t) : '0;
  endfunction

  // Configuration registers
  logic [5:0]       owed_limit;
  logic [CNT_W-1:0] drain_target;

  // Ring pointers
  logic [PTR_W-1:0] send_ptr, recv_ptr, peer_recv_ptr, credit_reported_ptr;
  logic [PTR_W-1:0] send_ptr_next, recv_ptr_next, peer_recv_ptr_next;
  logic [PTR_W-1:0] credit_reported_ptr_next;

  // Counter memories with per-entry valid bits
  logic [CNT_W-1:0] sent_mem [TYPE_COUNT];
  logic [CNT_W-1:0] rcv_mem  [TYPE_COUNT];
  logic [TYPE_COUNT-1:0] sent_vld, rcv_vld;
  logic [CNT_W-1:0] sent_rd, rcv_rd;
  logic             sent_rd_ok, rcv_rd_ok;

  // Last write of each memory, for forwarding
  logic             sw_v, rw_v;
  logic [TW-1:0]    sw_addr, rw_addr;
  logic [CNT_W-1:0] sw_data, rw_data;

  // Received put count shadow for drain status
  logic [CNT_W-1:0] put_count, put_count_next;

  // Compute stage
  logic          s1_v;
  req_t          s1_req;
  logic [TW-1:0] s1_sidx, s1_ridx;
  logic          s1_adv, in_xfer;

  logic             sent_we, rcv_we;
  logic [CNT_W-1:0] sent_wdata, rcv_wdata, sent_cur, rcv_cur;
  logic [PTR_W-1:0] free_now, free_arr, owed;
  rsp_t             rsp_next;

  // Handshake
  assign s1_adv    = s1_v && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_v && !s1_adv;
  assign in_xfer   = req_valid && !req_stall;

  // APB port
  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_OWED_LIMIT:   prdata = {26'b0, owed_limit};
      REG_DRAIN_TARGET: prdata = drain_target;
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owed_limit   <= 6'd16;
      drain_target <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_OWED_LIMIT:   owed_limit   <= pwdata[5:0];
        REG_DRAIN_TARGET: drain_target <= pwdata;
        default: ;
      endcase
    end
  end

  // Memory read at transfer, write back from the compute stage
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (req.command == CMD_SEND) begin
        sent_rd    <= sent_mem[clamp_type(req.msg_type)];
        sent_rd_ok <= sent_vld[clamp_type(req.msg_type)];
      end else begin
        sent_rd    <= sent_mem[NOP_IDX];
        sent_rd_ok <= sent_vld[NOP_IDX];
      end
      rcv_rd    <= rcv_mem[clamp_type(req.msg_type)];
      rcv_rd_ok <= rcv_vld[clamp_type(req.msg_type)];
    end
    if (sent_we) begin
      sent_mem[s1_sidx] <= sent_wdata;
    end
    if (rcv_we) begin
      rcv_mem[s1_ridx] <= rcv_wdata;
    end
  end

  // Valid bits and last-write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sent_vld <= '0;
      rcv_vld  <= '0;
      sw_v     <= 1'b0;
      rw_v     <= 1'b0;
    end else begin
      if (sent_we) begin
        sent_vld[s1_sidx] <= 1'b1;
        sw_v              <= 1'b1;
      end
      if (rcv_we) begin
        rcv_vld[s1_ridx] <= 1'b1;
        rw_v             <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sent_we) begin
      sw_addr <= s1_sidx;
      sw_data <= sent_wdata;
    end
    if (rcv_we) begin
      rw_addr <= s1_ridx;
      rw_data <= rcv_wdata;
    end
  end

  // Capture the item into the compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (in_xfer) begin
      s1_v <= 1'b1;
    end else if (s1_adv) begin
      s1_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_req  <= req;
      s1_ridx <= clamp_type(req.msg_type);
      s1_sidx <= (req.command == CMD_SEND) ? clamp_type(req.msg_type) : NOP_IDX;
    end
  end

  // Forward the last write over the memory read
  always_comb begin
    if (sw_v && sw_addr == s1_sidx) begin
      sent_cur = sw_data;
    end else begin
      sent_cur = sent_rd_ok ? sent_rd : '0;
    end
    if (rw_v && rw_addr == s1_ridx) begin
      rcv_cur = rw_data;
    end else begin
      rcv_cur = rcv_rd_ok ? rcv_rd : '0;
    end
  end

  // Compute the result and the state update
  always_comb begin
    send_ptr_next            = send_ptr;
    recv_ptr_next            = recv_ptr;
    peer_recv_ptr_next       = peer_recv_ptr;
    credit_reported_ptr_next = credit_reported_ptr;
    put_count_next           = put_count;
    sent_we    = 1'b0;
    rcv_we     = 1'b0;
    sent_wdata = sent_cur + 1'b1;
    rcv_wdata  = rcv_cur + 1'b1;
    rsp_next   = '0;

    free_now = peer_recv_ptr - send_ptr - 1'b1;
    free_arr = PTR_W'(s1_req.peer_credit) - send_ptr - 1'b1;
    owed     = (recv_ptr + 1'b1) - credit_reported_ptr;

    if (s1_req.command == CMD_SEND) begin
      if (free_now == '0) begin
        rsp_next.status     = ST_NO_CREDIT;
        rsp_next.type_total = sent_cur;
        rsp_next.send_space = 6'(free_now);
      end else begin
        rsp_next.status      = ST_SENT;
        rsp_next.out_valid   = 1'b1;
        rsp_next.out_type    = s1_req.msg_type;
        rsp_next.out_credit  = 6'(recv_ptr);
        rsp_next.out_slot    = 6'(send_ptr);
        rsp_next.out_payload = s1_req.payload;
        rsp_next.type_total  = sent_wdata;
        rsp_next.send_space  = 6'(free_now - 1'b1);
        sent_we                  = s1_adv;
        credit_reported_ptr_next = recv_ptr;
        send_ptr_next            = send_ptr + 1'b1;
      end
    end else if (s1_req.msg_type == 8'(IDLE_CODE)) begin
      rsp_next.status     = ST_IDLE;
      rsp_next.send_space = 6'(free_now);
    end else begin
      rsp_next.status     = ST_ARRIVED;
      rsp_next.type_total = rcv_wdata;
      rcv_we              = s1_adv;
      peer_recv_ptr_next  = PTR_W'(s1_req.peer_credit);
      recv_ptr_next       = recv_ptr + 1'b1;
      if (s1_ridx == PUT_IDX) begin
        put_count_next = rcv_wdata;
      end
      // Return credit with a nop when enough is owed and a slot is free
      if (owed > owed_limit && free_arr != '0) begin
        rsp_next.out_valid  = 1'b1;
        rsp_next.out_type   = 8'(NOP_CODE);
        rsp_next.out_credit = 6'(recv_ptr + 1'b1);
        rsp_next.out_slot   = 6'(send_ptr);
        rsp_next.send_space = 6'(free_arr - 1'b1);
        sent_we                  = s1_adv;
        credit_reported_ptr_next = recv_ptr + 1'b1;
        send_ptr_next            = send_ptr + 1'b1;
      end else begin
        rsp_next.send_space = 6'(free_arr);
      end
    end
    rsp_next.drain_done = (put_count_next >= drain_target);
  end

  // Advance pointers when the item leaves the compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      send_ptr            <= '0;
      recv_ptr            <= '0;
      peer_recv_ptr       <= '0;
      credit_reported_ptr <= '0;
      put_count           <= '0;
    end else if (s1_adv) begin
      send_ptr            <= send_ptr_next;
      recv_ptr            <= recv_ptr_next;
      peer_recv_ptr       <= peer_recv_ptr_next;
      credit_reported_ptr <= credit_reported_ptr_next;
      put_count           <= put_count_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the credit ring endpoint: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import crep_pkg::*;

  localparam int          CLK_PERIOD  = 8;
  localparam int          LIMIT_NS    = 4_000_000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          SETTLE      = 4;
  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 64;
  localparam int unsigned TYPE_SLOTS  = 8;
  localparam logic [7:0]  IDLE_TYPE   = 8'd0;
  localparam logic [7:0]  NOP_TYPE    = 8'd1;
  localparam logic [7:0]  PUT_TYPE    = 8'd2;
  localparam logic [2:0]  ADDR_THRESH = {REG_OWED_LIMIT, 2'b00};
  localparam logic [2:0]  ADDR_DRAIN  = {REG_DRAIN_TARGET, 2'b00};

  typedef struct {
    bit          is_cfg;
    logic [2:0]  addr;
    logic [31:0] wdata;
    req_t        item;
    bit          typed;
    rsp_t        want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Endpoint mirror: pointers, counters and register copies
  logic [5:0]  snd_ptr;
  logic [5:0]  rcv_ptr;
  logic [5:0]  peer_ptr;
  logic [5:0]  rep_ptr;
  logic [31:0] sent_cnt [TYPE_SLOTS];
  logic [31:0] rcvd_cnt [TYPE_SLOTS];
  logic [5:0]  cfg_thresh;
  logic [31:0] cfg_drain;

  rsp_t        want_q [$];
  rsp_t        want;
  plan_row_t   plan [$];

  int unsigned mismatches   = 0;
  int unsigned items_in     = 0;
  int unsigned settings     = 0;
  int unsigned st_seen [4]  = '{0, 0, 0, 0};
  int unsigned nops_seen    = 0;
  int unsigned send_pct     = 30;
  int unsigned stall_pct    = 30;
  bit          hold_out     = 1'b0;

  credit_ring_endpoint dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    #(LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Counter slot of a type code; out-of-range codes land in slot 0
  function automatic logic [2:0] type_slot(logic [7:0] ty);
    return (ty < TYPE_SLOTS) ? ty[2:0] : 3'd0;
  endfunction

  function automatic logic [5:0] free_slots();
    return peer_ptr - snd_ptr - 6'd1;
  endfunction

  // Write one message into the send ring and report our receive pointer
  function automatic void emit_msg(inout rsp_t o, input logic [7:0] ty, input logic [63:0] word);
    logic [2:0] t;
    t             = type_slot(ty);
    o.out_valid   = 1'b1;
    o.out_type    = ty;
    o.out_credit  = rcv_ptr;
    o.out_slot    = snd_ptr;
    o.out_payload = word;
    rep_ptr       = rcv_ptr;
    snd_ptr       = snd_ptr + 6'd1;
    sent_cnt[t]   = sent_cnt[t] + 32'd1;
  endfunction

  // Advance the mirror by one transfer and return the result it should produce
  function automatic rsp_t endpoint_step(req_t r);
    rsp_t       o;
    logic [2:0] t;
    logic [5:0] owed;
    o = '0;
    t = type_slot(r.msg_type);
    if (r.command == CMD_SEND) begin
      if (free_slots() == 6'd0) begin
        o.status = ST_NO_CREDIT;
      end else begin
        o.status = ST_SENT;
        emit_msg(o, r.msg_type, r.payload);
      end
      o.type_total = sent_cnt[t];
    end else if (r.msg_type == IDLE_TYPE) begin
      o.status = ST_IDLE;
    end else begin
      o.status     = ST_ARRIVED;
      peer_ptr     = r.peer_credit;
      rcvd_cnt[t]  = rcvd_cnt[t] + 32'd1;
      o.type_total = rcvd_cnt[t];
      rcv_ptr      = rcv_ptr + 6'd1;
      owed         = rcv_ptr - rep_ptr;
      // return credit with a nop, but only if a slot is free
      if (owed > cfg_thresh && free_slots() != 6'd0) emit_msg(o, NOP_TYPE, 64'd0);
    end
    o.send_space = free_slots();
    o.drain_done = rcvd_cnt[type_slot(PUT_TYPE)] >= cfg_drain;
    return o;
  endfunction

  function automatic int unsigned gap_len(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic plan_row_t item_row(logic cmd, logic [7:0] ty, logic [5:0] cr,
                                         logic [63:0] pl);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.addr   = '0;
    row.wdata  = '0;
    row.item   = {cmd, ty, cr, pl};
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [2:0] addr, logic [31:0] data);
    plan_row_t row;
    row        = item_row(CMD_SEND, 8'd0, 6'd0, 64'd0);
    row.is_cfg = 1'b1;
    row.addr   = addr;
    row.wdata  = data;
    return row;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
  endtask

  // Offer one item after a random gap; predict it at its transfer edge
  task automatic push_item(req_t r, bit typed, rsp_t typed_want);
    int unsigned n;
    rsp_t        pred;
    n = gap_len(send_pct);
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pred = endpoint_step(r);
    want_q.push_back(typed ? typed_want : pred);
    items_in++;
  endtask

  // Wait out every pending result plus the pipeline tail
  task automatic drain_results();
    while (want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    req_valid <= 1'b0;
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_THRESH) cfg_thresh = data[5:0];
    else cfg_drain = data;
    settings++;
  endtask

  // Receiver: random stalls, plus one long hold counted here
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_left = HOLD_CYCLES;
        hold_out  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
        stall_left = gap_len(stall_pct);
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", rsp.status));
      end else begin
        want = want_q.pop_front();
        check_field("status", rsp.status, want.status);
        check_field("out_valid", rsp.out_valid, want.out_valid);
        check_field("out_type", rsp.out_type, want.out_type);
        check_field("out_credit", rsp.out_credit, want.out_credit);
        check_field("out_slot", rsp.out_slot, want.out_slot);
        check_field("out_payload", rsp.out_payload, want.out_payload);
        check_field("type_total", rsp.type_total, want.type_total);
        check_field("send_space", rsp.send_space, want.send_space);
        check_field("drain_done", rsp.drain_done, want.drain_done);
      end
      st_seen[rsp.status]++;
      if (rsp.status == ST_ARRIVED && rsp.out_valid) nops_seen++;
    end
  end

  initial begin
    plan_row_t   row;
    req_t        r;
    rsp_t        none;
    logic [5:0]  outstanding;
    logic [5:0]  th;
    logic [31:0] dt;
    int unsigned arrive_pct;

    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    none       = '0;

    snd_ptr    = '0;
    rcv_ptr    = '0;
    peer_ptr   = '0;
    rep_ptr    = '0;
    cfg_thresh = 6'd16;
    cfg_drain  = '0;
    for (int i = 0; i < TYPE_SLOTS; i++) begin
      sent_cnt[i] = '0;
      rcvd_cnt[i] = '0;
    end

    // Directed table; typed results hold only where the value is obvious
    row = item_row(CMD_ARRIVE, IDLE_TYPE, 6'h3F, '1);
    row.typed = 1'b1;
    row.want  = '{ST_IDLE, 1'b0, 8'd0, 6'd0, 6'd0, 64'd0, 32'd0, 6'd63, 1'b1};
    plan.push_back(row);
    row = item_row(CMD_SEND, 8'hFF, 6'h3F, '1);
    row.typed = 1'b1;
    row.want  = '{ST_SENT, 1'b1, 8'hFF, 6'd0, 6'd0, '1, 32'd1, 6'd62, 1'b1};
    plan.push_back(row);
    plan.push_back(item_row(CMD_SEND, 8'd0, 6'd0, 64'd0));
    plan.push_back(item_row(CMD_SEND, 8'(TYPE_SLOTS - 1), 6'd0, 64'h0123_4567_89AB_CDEF));
    plan.push_back(item_row(CMD_SEND, 8'(TYPE_SLOTS), 6'd0, 64'h8000_0000_0000_0001));
    plan.push_back(item_row(CMD_ARRIVE, PUT_TYPE, 6'd0, 64'd0));
    plan.push_back(item_row(CMD_ARRIVE, 8'hFF, 6'h3F, 64'd0));
    // peer pointer one past our send pointer closes the credit window
    plan.push_back(item_row(CMD_ARRIVE, NOP_TYPE, 6'd5, 64'd0));
    row = item_row(CMD_SEND, 8'd3, 6'd0, 64'hDEAD_BEEF_0000_0001);
    row.typed = 1'b1;
    row.want  = '{ST_NO_CREDIT, 1'b0, 8'd0, 6'd0, 6'd0, 64'd0, 32'd0, 6'd0, 1'b1};
    plan.push_back(row);
    plan.push_back(item_row(CMD_SEND, 8'hFF, 6'd0, '1));
    plan.push_back(cfg_row(ADDR_THRESH, 32'hFFFF_FFC0));
    // nop wanted while the window is still closed, then once it opens
    plan.push_back(item_row(CMD_ARRIVE, PUT_TYPE, 6'd5, 64'd0));
    plan.push_back(item_row(CMD_ARRIVE, 8'd3, 6'd20, 64'd0));
    plan.push_back(item_row(CMD_SEND, PUT_TYPE, 6'd0, 64'h5555_5555_AAAA_AAAA));
    plan.push_back(cfg_row(ADDR_DRAIN, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(ADDR_THRESH, 32'h0000_003F));
    plan.push_back(item_row(CMD_ARRIVE, PUT_TYPE, 6'd20, 64'd0));
    plan.push_back(cfg_row(ADDR_DRAIN, 32'd4));
    plan.push_back(item_row(CMD_SEND, 8'd5, 6'd0, 64'd7));
    plan.push_back(item_row(CMD_ARRIVE, PUT_TYPE, 6'd20, 64'd0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].is_cfg) cfg_write(plan[i].addr, plan[i].wdata);
      else push_item(plan[i].item, plan[i].typed, plan[i].want);
    end

    // Random phases, each with fresh register values
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       th = 6'd0;
        1:       th = 6'd63;
        2:       th = 6'($urandom_range(1, 8));
        default: th = 6'($urandom);
      endcase
      if (p == 0) dt = 32'hFFFF_FFFF;
      else if (p == 1) dt = 32'd0;
      else dt = $urandom_range(0, 30);
      cfg_write(ADDR_THRESH, {26'($urandom), th});
      cfg_write(ADDR_DRAIN, dt);

      arrive_pct = 35 + 15 * (p % 3);
      send_pct   = (p == 3 || p == 5) ? 0 : 30;
      stall_pct  = (p == 3) ? 0 : 30;
      if (p == 5) hold_out = 1'b1;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r.payload     = {$urandom, $urandom};
        r.peer_credit = 6'($urandom);
        r.msg_type    = 8'($urandom_range(0, TYPE_SLOTS - 1));
        if ($urandom_range(0, 99) < 12) r.msg_type = 8'($urandom);
        if ($urandom_range(0, 99) < arrive_pct) begin
          r.command = CMD_ARRIVE;
          if ($urandom_range(0, 99) < 10) r.msg_type = IDLE_TYPE;
          else if (r.msg_type == IDLE_TYPE) r.msg_type = PUT_TYPE;
          // in most items the peer acknowledges somewhere between its last report and our send pointer
          if ($urandom_range(0, 99) < 85) begin
            outstanding   = snd_ptr - peer_ptr;
            r.peer_credit = peer_ptr + 6'($urandom_range(0, outstanding));
          end
        end else begin
          r.command = CMD_SEND;
        end
        push_item(r, 1'b0, none);
      end
    end

    req_valid <= 1'b0;
    drain_results();
    $display("tb_top: %0d items under %0d register writes; %0d sent, %0d refused for no credit",
             items_in, settings, st_seen[ST_SENT], st_seen[ST_NO_CREDIT]);
    $display("tb_top: %0d arrivals (%0d with a credit-return nop), %0d idle headers",
             st_seen[ST_ARRIVED], nops_seen, st_seen[ST_IDLE]);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/crep_pkg.sv
rtl/credit_ring_endpoint.sv
dv/tb_top.sv
